@@ rtl/lru_cache_directory_assert.svh @@
// Assertion macros for the LRU cache directory.
`ifndef LRU_CACHE_DIRECTORY_ASSERT_SVH
`define LRU_CACHE_DIRECTORY_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LCD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lru_cache_directory: check failed");

// next-cycle implication, disabled while reset is low
`define LCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lru_cache_directory: check failed");

`endif

@@ rtl/lcd_pkg.sv @@
// Package: sizes, command/result types for the LRU cache directory.
`default_nettype none
package lcd_pkg;
    localparam int NUM_WAYS    = 8;
    localparam int WAY_BITS    = $clog2(NUM_WAYS);
    localparam int BLOCK_WORDS = 4;
    localparam int OFF_BITS    = $clog2(BLOCK_WORDS);
    localparam int ADDR_BITS   = 16;
    localparam int TAG_BITS    = ADDR_BITS - OFF_BITS;
    localparam int CNT_BITS    = 32;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch request beat
        logic commit;   // look up, update directory, load result register
    } t_ctrl_cmd;

    // one result beat
    typedef struct packed {
        logic                 hit;
        logic [WAY_BITS-1:0]  way;
        logic                 writeback_needed;
        logic [ADDR_BITS-1:0] writeback_address;
        logic [ADDR_BITS-1:0] fill_address;
        logic [OFF_BITS-1:0]  word_offset;
        logic [CNT_BITS-1:0]  hit_total;
        logic [CNT_BITS-1:0]  miss_total;
    } t_rsp;
endpackage
`default_nettype wire

@@ rtl/lcd_if.sv @@
// Request and response channel interfaces of the LRU cache directory.
`default_nettype none
interface lcd_req_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [lcd_pkg::ADDR_BITS-1:0] address;

    modport source (output valid, cmd, address, input ready);
    modport sink   (input valid, cmd, address, output ready);
endinterface

interface lcd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [lcd_pkg::WAY_BITS-1:0]  way;
    logic                          writeback_needed;
    logic [lcd_pkg::ADDR_BITS-1:0] writeback_address;
    logic [lcd_pkg::ADDR_BITS-1:0] fill_address;
    logic [lcd_pkg::OFF_BITS-1:0]  word_offset;
    logic [lcd_pkg::CNT_BITS-1:0]  hit_total;
    logic [lcd_pkg::CNT_BITS-1:0]  miss_total;

    modport source (output valid, hit, way, writeback_needed, writeback_address,
                    fill_address, word_offset, hit_total, miss_total, input ready);
    modport sink   (input valid, hit, way, writeback_needed, writeback_address,
                    fill_address, word_offset, hit_total, miss_total, output ready);
endinterface
`default_nettype wire

@@ rtl/lcd_ctrl.sv @@
// Controller: request/response handshake and sequencing of the datapath.
`default_nettype none
module lcd_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output lcd_pkg::t_ctrl_cmd      o_cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic commit;

    // no beat taken while reset is held
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    // result slot free, or being emptied this cycle
    assign commit      = (r_state == S_LOOK) && (!r_out_valid || i_out_ready);

    assign o_cmd.capture = i_in_valid && o_in_ready;
    assign o_cmd.commit  = commit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (commit) n_out_valid = 1'b1;
        else        n_out_valid = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

@@ rtl/lcd_dpath.sv @@
// Datapath: tag store, LRU ranks, victim choice, counters and result register.
`default_nettype none
module lcd_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lcd_pkg::t_ctrl_cmd            i_cmd,
    input  wire logic                          i_req_cmd,
    input  wire logic [lcd_pkg::ADDR_BITS-1:0] i_req_address,
    output lcd_pkg::t_rsp                      o_rsp
);
    localparam int NW = lcd_pkg::NUM_WAYS;
    localparam int WB = lcd_pkg::WAY_BITS;
    localparam int TB = lcd_pkg::TAG_BITS;
    localparam int OB = lcd_pkg::OFF_BITS;
    localparam int AB = lcd_pkg::ADDR_BITS;
    localparam int CB = lcd_pkg::CNT_BITS;

    // latched request
    logic          r_is_write;
    logic [AB-1:0] r_addr;

    // directory
    logic          r_valid [NW];
    logic          r_dirty [NW];
    logic [TB-1:0] r_tag   [NW];
    logic [WB-1:0] r_rank  [NW];
    logic [CB-1:0] r_hit_cnt, r_miss_cnt;

    logic [WB-1:0] n_rank  [NW];
    logic [CB-1:0] n_hit_cnt, n_miss_cnt;

    lcd_pkg::t_rsp r_rsp;

    logic [TB-1:0] req_tag;
    logic [OB-1:0] req_off;
    logic          hit_any, inv_any, wb_need;
    logic [WB-1:0] hit_way, inv_way, lru_way, sel_way, old_rank;

    assign req_tag = r_addr[AB-1:OB];
    assign req_off = r_addr[OB-1:0];

    // parallel compares; lowest index wins
    always_comb begin
        hit_any = 1'b0;
        inv_any = 1'b0;
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int i = NW - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == req_tag)) begin
                hit_any = 1'b1;
                hit_way = WB'(i);
            end
            if (!r_valid[i]) begin
                inv_any = 1'b1;
                inv_way = WB'(i);
            end
            if (r_rank[i] == WB'(NW - 1)) lru_way = WB'(i);
        end
    end

    assign sel_way  = hit_any ? hit_way : (inv_any ? inv_way : lru_way);
    assign old_rank = r_rank[sel_way];
    assign wb_need  = !hit_any && r_valid[sel_way] && r_dirty[sel_way];

    // move touched way to front
    always_comb begin
        for (int i = 0; i < NW; i++) begin
            if (WB'(i) == sel_way)       n_rank[i] = '0;
            else if (r_rank[i] < old_rank) n_rank[i] = r_rank[i] + WB'(1);
            else                         n_rank[i] = r_rank[i];
        end
    end

    assign n_hit_cnt  = r_hit_cnt + CB'(hit_any);
    assign n_miss_cnt = r_miss_cnt + CB'(!hit_any);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_write <= i_req_cmd;
            r_addr     <= i_req_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (!hit_any) r_tag[sel_way] <= req_tag;
            r_rsp.hit               <= hit_any;
            r_rsp.way               <= sel_way;
            r_rsp.writeback_needed  <= wb_need;
            r_rsp.writeback_address <= wb_need ? {r_tag[sel_way], OB'(0)} : '0;
            r_rsp.fill_address      <= hit_any ? '0 : {req_tag, OB'(0)};
            r_rsp.word_offset       <= req_off;
            r_rsp.hit_total         <= n_hit_cnt;
            r_rsp.miss_total        <= n_miss_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NW; i++) begin
                r_valid[i] <= 1'b0;
                r_dirty[i] <= 1'b0;
                r_rank[i]  <= WB'(NW - 1 - i);
            end
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else if (i_cmd.commit) begin
            r_valid[sel_way] <= 1'b1;
            r_dirty[sel_way] <= r_is_write || (hit_any && r_dirty[sel_way]);
            r_rank           <= n_rank;
            r_hit_cnt        <= n_hit_cnt;
            r_miss_cnt       <= n_miss_cnt;
        end
    end

    assign o_rsp = r_rsp;
endmodule
`default_nettype wire

@@ rtl/lru_cache_directory.sv @@
// Top level: tag and exact-LRU replacement directory of a fully associative cache.
//
//  port    dir  beat contents
//  i_req   in   cmd (0 read, 1 write), address
//  o_rsp   out  hit, way, writeback_needed, writeback_address, fill_address,
//               word_offset, hit_total, miss_total
//
// An access first latches the request beat; then the eight tag compares,
// victim choice and rank update run and the result lands in the output
// register. The controller keeps a single outstanding request, so a new
// beat is taken only once the previous lookup has committed.
// The output register holds a result while the next request is latched; the
// lookup stalls only when that register is still full and not being taken.
// Synchronous active-low reset: all ways invalid and clean, ranks 7..0 on
// ways 0..7, counters zero.
`default_nettype none
`include "lru_cache_directory_assert.svh"
module lru_cache_directory (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lcd_req_if.sink    i_req,
    lcd_rsp_if.source  o_rsp
);
    lcd_pkg::t_ctrl_cmd ctrl_cmd;
    lcd_pkg::t_rsp      rsp_data;

    // sequencing and handshakes
    lcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (ctrl_cmd)
    );

    // directory state and result register
    lcd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .i_req_cmd     (i_req.cmd),
        .i_req_address (i_req.address),
        .o_rsp         (rsp_data)
    );

    assign o_rsp.hit               = rsp_data.hit;
    assign o_rsp.way               = rsp_data.way;
    assign o_rsp.writeback_needed  = rsp_data.writeback_needed;
    assign o_rsp.writeback_address = rsp_data.writeback_address;
    assign o_rsp.fill_address      = rsp_data.fill_address;
    assign o_rsp.word_offset       = rsp_data.word_offset;
    assign o_rsp.hit_total         = rsp_data.hit_total;
    assign o_rsp.miss_total        = rsp_data.miss_total;

    // one request in flight: an accepted beat blocks the next cycle
    `LCD_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    // a hit carries no writeback and no fill
    `LCD_ASSERT_NOW(a_hit_no_refill, i_clk, i_rst_n, o_rsp.valid && o_rsp.hit, !o_rsp.writeback_needed && (o_rsp.fill_address == 16'd0))
    // a fresh result only appears from the lookup cycle
    `LCD_ASSERT_NOW(a_result_from_lookup, i_clk, i_rst_n, $rose(o_rsp.valid), !$past(i_req.ready))
endmodule
`default_nettype wire
